// ----- rtl/sida_pkg.sv -----
// Shared constants for the signed integer to decimal text unit.
// Used by the top level and by its port checker; depends on nothing.
`timescale 1ns / 1ps

package sida_pkg;

  // Default width of the signed input value.
  localparam int unsigned DataWidthDef = 32;

  // Double-dabble bit steps that one pipeline stage performs.
  localparam int unsigned BitsPerStage = 8;

  // Width of one BCD digit.
  localparam int unsigned DigitWidth = 4;

  // ASCII codes that leave on the character port.
  localparam logic [6:0] CHAR_ZERO  = 7'd48;
  localparam logic [6:0] CHAR_NINE  = 7'd57;
  localparam logic [6:0] CHAR_MINUS = 7'd45;

endpackage

// ----- rtl/signed_int_to_decimal_ascii_unit.sv -----
// Path: an input value is registered in stage 0, then in each double-dabble stage and in the count
// stage, and the first character is offered from the serializer registers.
// Throughput: one character per cycle while the receiver does not stall; a text has 1 to 11
// characters at 32 bits, and the serializer sends them one after another.
// Reset: rst_ni is asynchronous and active low; it empties every stage and the serializer by
// clearing their valid and state bits, but the data registers are not reset.
`timescale 1ns / 1ps

// Top level of the signed integer to decimal ASCII converter.
// Depends on sida_pkg for the ASCII codes and the pipeline stage size.
module signed_int_to_decimal_ascii_unit #(
  parameter int unsigned DATA_WIDTH = sida_pkg::DataWidthDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Input channel.
  input  logic [DATA_WIDTH-1:0] value_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  // Output channel, one character per transfer.
  output logic [6:0]            char_code_o,
  output logic                  is_last_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i
);

  // Number of decimal digits in the largest magnitude, 2^(DATA_WIDTH-1).
  // The factor 30103/100000 stands for log10(2).
  localparam int unsigned NumDigits = ((DATA_WIDTH - 1) * 30103) / 100000 + 1;
  localparam int unsigned BcdWidth  = NumDigits * sida_pkg::DigitWidth;
  // The shift word holds the BCD digits above the binary magnitude.
  localparam int unsigned ShWidth   = BcdWidth + DATA_WIDTH;
  // Double-dabble stages; the last one may do fewer bit steps.
  localparam int unsigned NumStages =
      (DATA_WIDTH + sida_pkg::BitsPerStage - 1) / sida_pkg::BitsPerStage;
  localparam int unsigned IdxWidth  = $clog2(NumDigits);

  // ---------------------------------------------------------------------------------------------
  // Pipeline of the conversion.
  // Stage 0 takes the sign and forms the unsigned magnitude. Stages 1 to NumStages each run
  // up to eight steps of the shift-and-add-3 algorithm on the shift word. A count stage then finds
  // the most significant nonzero digit, so that leading zeros are never sent.
  // Every stage has a valid bit, and a stage loads when it is empty or its successor loads,
  // so a stall on the output side backs up through the pipe without losing an item.
  // ---------------------------------------------------------------------------------------------
  logic [NumStages:0] v_q;
  logic [NumStages:0] adv;
  logic [ShWidth-1:0] sh_q [0:NumStages];
  logic [ShWidth-1:0] sh_d [0:NumStages];
  logic               neg_q [0:NumStages];

  logic                cnt_v_q;
  logic                cnt_neg_q;
  logic [BcdWidth-1:0] cnt_bcd_q;
  logic [IdxWidth-1:0] cnt_msd_q;
  logic [IdxWidth-1:0] cnt_msd_d;
  logic                cnt_en;

  // Serializer state. The output port is driven straight from these registers, so it stays
  // put while the receiver stalls.
  logic                ser_busy_q;
  logic                ser_minus_q;
  logic [BcdWidth-1:0] ser_bcd_q;
  logic [IdxWidth-1:0] ser_ptr_q;
  logic                out_xfer;
  logic                ser_load;

  // Stage 0: magnitude. Negating the most negative value yields 2^(DATA_WIDTH-1), which is
  // exactly its unsigned magnitude.
  always_comb begin
    sh_d[0] = {{BcdWidth{1'b0}},
               (value_i[DATA_WIDTH-1] ? (~value_i + {{(DATA_WIDTH-1){1'b0}}, 1'b1}) : value_i)};
  end

  // Double-dabble stages.
  for (genvar s = 1; s <= NumStages; s++) begin : g_dabble
    always_comb begin : p_dabble
      logic [ShWidth-1:0] t;
      t = sh_q[s-1];
      for (int j = 0; j < sida_pkg::BitsPerStage; j++) begin
        if ((s - 1) * sida_pkg::BitsPerStage + j < DATA_WIDTH) begin
          for (int d = 0; d < NumDigits; d++) begin
            if (t[DATA_WIDTH + d*sida_pkg::DigitWidth +: sida_pkg::DigitWidth] >= 4'd5) begin
              t[DATA_WIDTH + d*sida_pkg::DigitWidth +: sida_pkg::DigitWidth] =
                  t[DATA_WIDTH + d*sida_pkg::DigitWidth +: sida_pkg::DigitWidth] + 4'd3;
            end
          end
          t = {t[ShWidth-2:0], 1'b0};
        end
      end
      sh_d[s] = t;
    end
  end

  // Load enables, walked back from the serializer.
  always_comb begin
    adv[NumStages] = !v_q[NumStages] || cnt_en;
    for (int s = NumStages - 1; s >= 0; s--) begin
      adv[s] = !v_q[s] || adv[s+1];
    end
  end

  assign in_stall_o = !adv[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (adv[0]) begin
        v_q[0] <= in_valid_i;
      end
      for (int s = 1; s <= NumStages; s++) begin
        if (adv[s]) begin
          v_q[s] <= v_q[s-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      sh_q[0]  <= sh_d[0];
      neg_q[0] <= value_i[DATA_WIDTH-1];
    end
    for (int s = 1; s <= NumStages; s++) begin
      if (adv[s]) begin
        sh_q[s]  <= sh_d[s];
        neg_q[s] <= neg_q[s-1];
      end
    end
  end

  // Count stage: index of the highest nonzero digit; zero gives index 0 and so a single '0'.
  always_comb begin
    cnt_msd_d = '0;
    for (int d = 0; d < NumDigits; d++) begin
      if (sh_q[NumStages][DATA_WIDTH + d*sida_pkg::DigitWidth +: sida_pkg::DigitWidth] != '0)
      begin
        cnt_msd_d = IdxWidth'(d);
      end
    end
  end

  assign cnt_en = !cnt_v_q || ser_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_v_q <= 1'b0;
    end else if (cnt_en) begin
      cnt_v_q <= v_q[NumStages];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cnt_en) begin
      cnt_neg_q <= neg_q[NumStages];
      cnt_bcd_q <= sh_q[NumStages][ShWidth-1 -: BcdWidth];
      cnt_msd_q <= cnt_msd_d;
    end
  end

  // ---------------------------------------------------------------------------------------------
  // Serializer. It sends a pending minus sign first, then the digits from the most significant
  // nonzero one down to the units digit. On the transfer of the last character it takes the
  // next item from the count stage in the same cycle, so texts follow back to back.
  // ---------------------------------------------------------------------------------------------
  assign out_xfer = ser_busy_q && !out_stall_i;
  assign ser_load = !ser_busy_q || (out_xfer && is_last_o);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ser_busy_q  <= 1'b0;
      ser_minus_q <= 1'b0;
      ser_ptr_q   <= '0;
    end else if (ser_load) begin
      ser_busy_q  <= cnt_v_q;
      ser_minus_q <= cnt_neg_q;
      ser_ptr_q   <= cnt_msd_q;
    end else if (out_xfer) begin
      if (ser_minus_q) begin
        ser_minus_q <= 1'b0;
      end else begin
        ser_ptr_q <= ser_ptr_q - IdxWidth'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ser_load) begin
      ser_bcd_q <= cnt_bcd_q;
    end
  end

  assign out_valid_o = ser_busy_q;
  assign is_last_o   = !ser_minus_q && (ser_ptr_q == '0);
  assign char_code_o = ser_minus_q ? sida_pkg::CHAR_MINUS
                     : sida_pkg::CHAR_ZERO
                       + {3'b000, ser_bcd_q[ser_ptr_q*sida_pkg::DigitWidth +: sida_pkg::DigitWidth]};

endmodule

// ----- rtl/sida_checker.sv -----
// Port checker for the signed integer to decimal text unit, with its bind statement.
// Depends on sida_pkg and on the top level signed_int_to_decimal_ascii_unit.
`timescale 1ns / 1ps

module sida_checker #(
  parameter int unsigned DATA_WIDTH = sida_pkg::DataWidthDef
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic [DATA_WIDTH-1:0] value_i,
  input logic                  in_valid_i,
  input logic                  in_stall_o,
  input logic [6:0]            char_code_o,
  input logic                  is_last_o,
  input logic                  out_valid_o,
  input logic                  out_stall_i
);

  // A stalled input value stays offered and unchanged.
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(value_i))
    else $error("stalled input value changed");

  // A stalled character stays offered and unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(char_code_o) && $stable(is_last_o))
    else $error("stalled output character changed");

  // Only a minus sign or a decimal digit ever leaves.
  a_char_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (char_code_o == sida_pkg::CHAR_MINUS) ||
                    ((char_code_o >= sida_pkg::CHAR_ZERO) && (char_code_o <= sida_pkg::CHAR_NINE)))
    else $error("output character is neither a minus sign nor a digit");

  // A minus sign is never the end of a text.
  a_minus_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (char_code_o == sida_pkg::CHAR_MINUS) |-> !is_last_o)
    else $error("minus sign flagged as last character");

  // The digit after a minus sign follows at once and is never a leading zero.
  a_minus_then_digit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && (char_code_o == sida_pkg::CHAR_MINUS)
    |=> out_valid_o && (char_code_o != sida_pkg::CHAR_ZERO) &&
        (char_code_o != sida_pkg::CHAR_MINUS))
    else $error("minus sign not followed by a nonzero digit");

endmodule

bind signed_int_to_decimal_ascii_unit sida_checker #(
  .DATA_WIDTH(DATA_WIDTH)
) u_sida_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .value_i    (value_i),
  .in_valid_i (in_valid_i),
  .in_stall_o (in_stall_o),
  .char_code_o(char_code_o),
  .is_last_o  (is_last_o),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i)
);
